/* src/i2c_sdra_pkg.sv */
`timescale 1ns / 1ps

package i2c_sdra_pkg;

  // Receive buffer geometry
  localparam int BUFFER_DEPTH = 14;
  localparam int SLOT_W       = 4;

  // Controller status codes
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_ACK   = 8'h28;
  localparam logic [7:0] ST_DATA_NACK  = 8'h30;
  localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK = 8'h48;
  localparam logic [7:0] ST_RX_ACK     = 8'h50;
  localparam logic [7:0] ST_RX_NACK    = 8'h58;
  localparam logic [7:0] ST_IDLE       = 8'hF8;

  // Control register bits
  localparam logic [7:0] CTL_START    = 8'h20;
  localparam logic [7:0] CTL_STOP_ACK = 8'h14;
  localparam logic [7:0] CTL_ACK      = 8'h04;
  localparam logic [7:0] CTL_INT      = 8'h08;
  localparam logic [7:0] CTL_NACK_CLR = 8'h3C;

  // Transaction kind
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_READ_LENGTH    = 2'd0;
  localparam logic [1:0] CFG_WRITE_LENGTH   = 2'd1;
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd2;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic              pad;
    logic              init_done;
    logic [7:0]        write_count;
    logic [7:0]        store_data;
    logic [SLOT_W-1:0] store_index;
    logic              store_valid;
    logic [7:0]        clear_mask;
    logic [7:0]        set_mask;
    logic [7:0]        tx_data;
    logic              tx_valid;
  } result_t;

  // Input word, last field in the lowest bits
  typedef struct packed {
    logic [7:0] rx_byte;
    logic [7:0] write_value;
    logic [7:0] reg_address;
    logic [7:0] status;
  } item_t;

endpackage

/* src/i2c_status_driven_register_access.sv */
`timescale 1ns / 1ps

// Channel  Dir  Payload
// in_      in   tdata: status, reg_address, write_value, rx_byte; tuser: kind
// out_     out  tdata: tx_valid .. init_done (48 bits, one result per item)
// cfg_     in   we, index (0 read_length, 1 write_length, 2 device_address), data
//
// One result per item, one item per cycle unless the output stalls: the status
// decode and counter update sit between the input port and the result register.
// The result is registered and appears in the cycle after the input transaction is accepted.
// rst_n (synchronous) clears the counters and the result valid flag and loads the
// configuration defaults.
// A stalled result holds the input side only when the result register is full.

module i2c_status_driven_register_access (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // status, reg_address, write_value, rx_byte
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // tx_valid, tx_data, set_mask, clear_mask, store_valid, store_index,
  // store_data, write_count, init_done, zero pad
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int SW = i2c_sdra_pkg::SLOT_W;

  logic [3:0]    read_length_r;
  logic [7:0]    write_length_r;
  logic [6:0]    device_address_r;

  logic [2:0]    op_counter_r,  op_counter_nxt;
  logic [7:0]    writes_done_r, writes_done_nxt;
  logic [3:0]    reads_done_r,  reads_done_nxt;
  logic [SW-1:0] slot_index_r,  slot_index_nxt;
  logic          done_flag_r,   done_flag_nxt;

  i2c_sdra_pkg::result_t res_r, res_nxt;
  logic                  out_valid_r;

  i2c_sdra_pkg::item_t item;
  logic                in_acc;
  logic [7:0]          addr_w;
  logic [SW:0]         slot_inc;

  assign item      = i2c_sdra_pkg::item_t'(in_tdata);
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign addr_w    = {device_address_r, 1'b0};
  assign slot_inc  = {1'b0, slot_index_r} + {{SW{1'b0}}, 1'b1};

  always_comb begin
    res_nxt         = '0;
    op_counter_nxt  = op_counter_r;
    writes_done_nxt = writes_done_r;
    reads_done_nxt  = reads_done_r;
    slot_index_nxt  = slot_index_r;
    done_flag_nxt   = done_flag_r;

    if (in_tuser == i2c_sdra_pkg::KIND_WRITE) begin
      unique case (item.status) inside
        i2c_sdra_pkg::ST_START: begin
          op_counter_nxt     = '0;
          res_nxt.tx_valid   = 1'b1;
          res_nxt.tx_data    = addr_w;
          res_nxt.clear_mask = i2c_sdra_pkg::CTL_START;
          res_nxt.set_mask   = i2c_sdra_pkg::CTL_ACK;
        end
        i2c_sdra_pkg::ST_SLA_W_ACK: begin
          op_counter_nxt   = op_counter_r + 3'd1;
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_data  = item.reg_address;
        end
        i2c_sdra_pkg::ST_DATA_ACK: begin
          op_counter_nxt   = op_counter_r + 3'd1;
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_data  = item.write_value;
          // third step of a write completes it: restart and count it, or flag init done
          if (op_counter_nxt == 3'd3) begin
            res_nxt.set_mask = i2c_sdra_pkg::CTL_START;
            if (writes_done_r < write_length_r) begin
              writes_done_nxt = writes_done_r + 8'd1;
            end else begin
              done_flag_nxt = 1'b1;
            end
          end
        end
        i2c_sdra_pkg::ST_SLA_W_NACK, i2c_sdra_pkg::ST_DATA_NACK: begin
          res_nxt.set_mask = i2c_sdra_pkg::CTL_STOP_ACK;
        end
        default: begin
        end
      endcase
    end else begin
      unique case (item.status) inside
        i2c_sdra_pkg::ST_START: begin
          res_nxt.tx_valid   = 1'b1;
          res_nxt.tx_data    = addr_w;
          res_nxt.clear_mask = i2c_sdra_pkg::CTL_START;
          res_nxt.set_mask   = i2c_sdra_pkg::CTL_ACK;
        end
        i2c_sdra_pkg::ST_RESTART: begin
          res_nxt.tx_valid   = 1'b1;
          res_nxt.tx_data    = addr_w | 8'h01;
          res_nxt.clear_mask = i2c_sdra_pkg::CTL_START;
          res_nxt.set_mask   = i2c_sdra_pkg::CTL_ACK;
        end
        i2c_sdra_pkg::ST_SLA_W_ACK: begin
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_data  = item.reg_address;
        end
        i2c_sdra_pkg::ST_SLA_W_NACK, i2c_sdra_pkg::ST_DATA_NACK: begin
          res_nxt.set_mask = i2c_sdra_pkg::CTL_STOP_ACK;
        end
        i2c_sdra_pkg::ST_DATA_ACK, i2c_sdra_pkg::ST_SLA_R_NACK: begin
          res_nxt.set_mask = i2c_sdra_pkg::CTL_START;
        end
        i2c_sdra_pkg::ST_SLA_R_ACK: begin
          res_nxt.set_mask = i2c_sdra_pkg::CTL_ACK;
        end
        i2c_sdra_pkg::ST_RX_ACK: begin
          res_nxt.store_valid = 1'b1;
          res_nxt.store_index = slot_index_r;
          res_nxt.store_data  = item.rx_byte;
          // wrap the slot at the end of the buffer
          if (slot_inc >= (SW+1)'(i2c_sdra_pkg::BUFFER_DEPTH)) begin
            slot_index_nxt = '0;
          end else begin
            slot_index_nxt = slot_inc[SW-1:0];
          end
          reads_done_nxt = reads_done_r + 4'd1;
          // drop the acknowledge so the next byte is NACKed
          if (reads_done_nxt == read_length_r) begin
            res_nxt.clear_mask = i2c_sdra_pkg::CTL_NACK_CLR;
          end
        end
        i2c_sdra_pkg::ST_RX_NACK: begin
          res_nxt.store_valid = 1'b1;
          res_nxt.store_index = slot_index_r;
          res_nxt.store_data  = item.rx_byte;
          res_nxt.set_mask    = i2c_sdra_pkg::CTL_STOP_ACK;
          slot_index_nxt      = '0;
          reads_done_nxt      = '0;
        end
        default: begin
        end
      endcase
    end

    if (item.status != i2c_sdra_pkg::ST_IDLE) begin
      res_nxt.clear_mask = res_nxt.clear_mask | i2c_sdra_pkg::CTL_INT;
    end
    res_nxt.write_count = writes_done_nxt;
    res_nxt.init_done   = done_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_length_r    <= 4'd13;
      write_length_r   <= 8'd13;
      device_address_r <= 7'd104;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2c_sdra_pkg::CFG_READ_LENGTH:    read_length_r    <= cfg_data[3:0];
        i2c_sdra_pkg::CFG_WRITE_LENGTH:   write_length_r   <= cfg_data;
        i2c_sdra_pkg::CFG_DEVICE_ADDRESS: device_address_r <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_counter_r  <= '0;
      writes_done_r <= '0;
      reads_done_r  <= '0;
      slot_index_r  <= '0;
      done_flag_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        op_counter_r  <= op_counter_nxt;
        writes_done_r <= writes_done_nxt;
        reads_done_r  <= reads_done_nxt;
        slot_index_r  <= slot_index_nxt;
        done_flag_r   <= done_flag_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

endmodule

/* src/i2c_sdra_checker.sv */
`timescale 1ns / 1ps

module i2c_sdra_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  i2c_sdra_pkg::result_t res;
  assign res = i2c_sdra_pkg::result_t'(out_tdata);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an empty or draining result register takes the next transaction
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input held off with result register free");

  // an accepted transaction always yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted transaction produced no result");

  // unused byte fields read as zero and the slot stays in the buffer
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.tx_valid || res.tx_data == 8'h00)
      && (res.store_valid || (res.store_index == '0 && res.store_data == 8'h00))
      && (res.store_index < i2c_sdra_pkg::SLOT_W'(i2c_sdra_pkg::BUFFER_DEPTH)))
    else $error("result field out of contract");

endmodule

bind i2c_status_driven_register_access i2c_sdra_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/sv/i2c_sdra_checker.sv */
`timescale 1ns / 1ps

module i2c_sdra_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // status, reg_address, write_value, rx_byte
  input  logic        in_tuser,   // kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  // tx_valid, tx_data, set_mask, clear_mask, store_valid, store_index,
  // store_data, write_count, init_done, zero pad
  input  logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          bytes_stored
);

  // Shadow of the register file
  logic [3:0] rd_len;
  logic [7:0] wr_len;
  logic [6:0] dev_addr;

  // Shadow of the sequencing state
  logic [2:0] op_cnt;
  logic [7:0] wr_done;
  logic [3:0] rd_done;
  logic [3:0] slot;
  logic       done;

  i2c_sdra_pkg::result_t expected_results[$];

  function automatic i2c_sdra_pkg::result_t decode_status(logic kind,
                                                          i2c_sdra_pkg::item_t it);
    i2c_sdra_pkg::result_t r;
    logic [7:0] addr_w;
    r = '0;
    addr_w = {dev_addr, 1'b0};
    if (kind == i2c_sdra_pkg::KIND_WRITE) begin
      case (it.status)
        i2c_sdra_pkg::ST_START: begin
          op_cnt       = '0;
          r.tx_valid   = 1'b1;
          r.tx_data    = addr_w;
          r.clear_mask = i2c_sdra_pkg::CTL_START;
          r.set_mask   = i2c_sdra_pkg::CTL_ACK;
        end
        i2c_sdra_pkg::ST_SLA_W_ACK: begin
          op_cnt     = op_cnt + 3'd1;
          r.tx_valid = 1'b1;
          r.tx_data  = it.reg_address;
        end
        i2c_sdra_pkg::ST_DATA_ACK: begin
          op_cnt     = op_cnt + 3'd1;
          r.tx_valid = 1'b1;
          r.tx_data  = it.write_value;
          // third byte of the write: restart and count it, or flag init done
          if (op_cnt == 3'd3) begin
            r.set_mask = i2c_sdra_pkg::CTL_START;
            if (wr_done < wr_len) wr_done = wr_done + 8'd1;
            else done = 1'b1;
          end
        end
        i2c_sdra_pkg::ST_SLA_W_NACK, i2c_sdra_pkg::ST_DATA_NACK: begin
          r.set_mask = i2c_sdra_pkg::CTL_STOP_ACK;
        end
        default: ;
      endcase
    end else begin
      case (it.status)
        i2c_sdra_pkg::ST_START: begin
          r.tx_valid   = 1'b1;
          r.tx_data    = addr_w;
          r.clear_mask = i2c_sdra_pkg::CTL_START;
          r.set_mask   = i2c_sdra_pkg::CTL_ACK;
        end
        i2c_sdra_pkg::ST_RESTART: begin
          r.tx_valid   = 1'b1;
          r.tx_data    = {dev_addr, 1'b1};
          r.clear_mask = i2c_sdra_pkg::CTL_START;
          r.set_mask   = i2c_sdra_pkg::CTL_ACK;
        end
        i2c_sdra_pkg::ST_SLA_W_ACK: begin
          r.tx_valid = 1'b1;
          r.tx_data  = it.reg_address;
        end
        i2c_sdra_pkg::ST_SLA_W_NACK, i2c_sdra_pkg::ST_DATA_NACK: begin
          r.set_mask = i2c_sdra_pkg::CTL_STOP_ACK;
        end
        i2c_sdra_pkg::ST_DATA_ACK, i2c_sdra_pkg::ST_SLA_R_NACK: begin
          r.set_mask = i2c_sdra_pkg::CTL_START;
        end
        i2c_sdra_pkg::ST_SLA_R_ACK: begin
          r.set_mask = i2c_sdra_pkg::CTL_ACK;
        end
        i2c_sdra_pkg::ST_RX_ACK: begin
          r.store_valid = 1'b1;
          r.store_index = slot;
          r.store_data  = it.rx_byte;
          slot    = (slot == i2c_sdra_pkg::SLOT_W'(i2c_sdra_pkg::BUFFER_DEPTH - 1)) ?
                    '0 : slot + 4'd1;
          rd_done = rd_done + 4'd1;
          // drop the acknowledge so the next byte goes out with NACK
          if (rd_done == rd_len) r.clear_mask = i2c_sdra_pkg::CTL_NACK_CLR;
        end
        i2c_sdra_pkg::ST_RX_NACK: begin
          r.store_valid = 1'b1;
          r.store_index = slot;
          r.store_data  = it.rx_byte;
          r.set_mask    = i2c_sdra_pkg::CTL_STOP_ACK;
          slot    = '0;
          rd_done = '0;
        end
        default: ;
      endcase
    end
    if (it.status != i2c_sdra_pkg::ST_IDLE) r.clear_mask = r.clear_mask | i2c_sdra_pkg::CTL_INT;
    r.write_count = wr_done;
    r.init_done   = done;
    return r;
  endfunction

  always @(posedge clk) begin
    i2c_sdra_pkg::result_t want;
    i2c_sdra_pkg::result_t got;
    if (!rst_n) begin
      rd_len   = 4'd13;
      wr_len   = 8'd13;
      dev_addr = 7'd104;
      op_cnt   = '0;
      wr_done  = '0;
      rd_done  = '0;
      slot     = '0;
      done     = 1'b0;
      expected_results.delete();
      fail_count   = 0;
      results_seen = 0;
      bytes_stored = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          i2c_sdra_pkg::CFG_READ_LENGTH:    rd_len   = cfg_data[3:0];
          i2c_sdra_pkg::CFG_WRITE_LENGTH:   wr_len   = cfg_data;
          i2c_sdra_pkg::CFG_DEVICE_ADDRESS: dev_addr = cfg_data[6:0];
          default: ;
        endcase
      end
      // compare before predicting: a result leaving now belongs to an older item
      if (out_tvalid && out_tready) begin
        got = i2c_sdra_pkg::result_t'(out_tdata);
        results_seen++;
        if (got.store_valid) bytes_stored++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result %h with nothing outstanding", out_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got.tx_valid !== want.tx_valid || got.tx_data !== want.tx_data ||
              got.set_mask !== want.set_mask || got.clear_mask !== want.clear_mask ||
              got.store_valid !== want.store_valid ||
              got.store_index !== want.store_index ||
              got.store_data !== want.store_data ||
              got.write_count !== want.write_count ||
              got.init_done !== want.init_done || got.pad !== want.pad) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d mismatch: tx %b/%h set %h clr %h rx %b/%0d/%h wc %0d done %b",
                       results_seen, got.tx_valid, got.tx_data, got.set_mask,
                       got.clear_mask, got.store_valid, got.store_index, got.store_data,
                       got.write_count, got.init_done);
              $display("          expected: tx %b/%h set %h clr %h rx %b/%0d/%h wc %0d done %b",
                       want.tx_valid, want.tx_data, want.set_mask, want.clear_mask,
                       want.store_valid, want.store_index, want.store_data,
                       want.write_count, want.init_done);
            end
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(decode_status(in_tuser,
                                                 i2c_sdra_pkg::item_t'(in_tdata)));
    end
    pending = expected_results.size();
  end

endmodule

/* tb/sv/i2c_status_driven_register_access_tb.sv */
`timescale 1ns / 1ps

module i2c_status_driven_register_access_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 210;

  localparam logic [7:0] KNOWN_CODES [11] = '{
    i2c_sdra_pkg::ST_START, i2c_sdra_pkg::ST_RESTART, i2c_sdra_pkg::ST_SLA_W_ACK,
    i2c_sdra_pkg::ST_SLA_W_NACK, i2c_sdra_pkg::ST_DATA_ACK, i2c_sdra_pkg::ST_DATA_NACK,
    i2c_sdra_pkg::ST_SLA_R_ACK, i2c_sdra_pkg::ST_SLA_R_NACK, i2c_sdra_pkg::ST_RX_ACK,
    i2c_sdra_pkg::ST_RX_NACK, i2c_sdra_pkg::ST_IDLE
  };

  // Register settings per phase; some carry junk above the register width
  localparam logic [7:0] RD_LEN_TAB [PHASES] = '{8'h01, 8'h0F, 8'h00, 8'hF7,
                                                 8'h05, 8'h0D, 8'h02, 8'h3C};
  localparam logic [7:0] WR_LEN_TAB [PHASES] = '{8'd6, 8'd255, 8'd0, 8'd40,
                                                 8'd3, 8'd13, 8'd255, 8'd2};
  localparam logic [7:0] ADDR_TAB   [PHASES] = '{8'h00, 8'h7F, 8'hD5, 8'h2A,
                                                 8'hFF, 8'h68, 8'h01, 8'h40};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // status, reg_address, write_value, rx_byte
  logic        in_tuser   = 1'b0; // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // tx_valid, tx_data, set_mask, clear_mask, store_valid, store_index,
  // store_data, write_count, init_done, zero pad
  logic [47:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [7:0]  cfg_data   = '0;

  int fail_count;
  int pending;
  int results_seen;
  int bytes_stored;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int items_sent    = 0;
  int cycles        = 0;
  logic [3:0] rd_len_now = 4'd13;

  i2c_status_driven_register_access dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  i2c_sdra_scoreboard u_scoreboard (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .bytes_stored (bytes_stored)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("i2c_status_driven_register_access regression: fail");
    $finish;
  end

  task automatic send_item(logic kind, logic [7:0] status, logic [7:0] reg_address,
                           logic [7:0] write_value, logic [7:0] rx_byte);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {rx_byte, write_value, reg_address, status};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Hold the input side, then wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] rd_len, logic [7:0] wr_len, logic [7:0] addr);
    cfg_we    <= 1'b1;
    cfg_index <= i2c_sdra_pkg::CFG_READ_LENGTH;
    cfg_data  <= rd_len;
    @(posedge clk);
    cfg_index <= i2c_sdra_pkg::CFG_WRITE_LENGTH;
    cfg_data  <= wr_len;
    @(posedge clk);
    cfg_index <= i2c_sdra_pkg::CFG_DEVICE_ADDRESS;
    cfg_data  <= addr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rd_len_now = rd_len[3:0];
  endtask

  // Mostly complete register writes and burst reads with random payloads,
  // some cut short or corrupted, the rest single stray status codes
  task automatic run_traffic(int n);
    int sent;
    int pick;
    int len;
    int cut;
    logic kind;
    logic [7:0] codes[$];
    sent = 0;
    while (sent < n) begin
      codes.delete();
      pick = $urandom_range(0, 99);
      kind = (pick < 40) ? i2c_sdra_pkg::KIND_WRITE : i2c_sdra_pkg::KIND_READ;
      if (pick >= 90) begin
        kind = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) codes.push_back(KNOWN_CODES[$urandom_range(0, 10)]);
        else codes.push_back(8'($urandom_range(0, 255)));
      end else begin
        codes.push_back(i2c_sdra_pkg::ST_START);
        codes.push_back(i2c_sdra_pkg::ST_SLA_W_ACK);
        if (kind == i2c_sdra_pkg::KIND_WRITE) begin
          len = ($urandom_range(0, 99) < 85) ? 2 : $urandom_range(1, 9);
          repeat (len) codes.push_back(i2c_sdra_pkg::ST_DATA_ACK);
        end else begin
          codes.push_back(i2c_sdra_pkg::ST_DATA_ACK);
          codes.push_back(i2c_sdra_pkg::ST_RESTART);
          codes.push_back(i2c_sdra_pkg::ST_SLA_R_ACK);
          if ($urandom_range(0, 99) < 80) len = (rd_len_now == 0) ? 16 : rd_len_now;
          else len = $urandom_range(0, 17);
          repeat (len) codes.push_back(i2c_sdra_pkg::ST_RX_ACK);
          codes.push_back(i2c_sdra_pkg::ST_RX_NACK);
        end
        if ($urandom_range(0, 99) < 15) begin
          cut = $urandom_range(1, codes.size());
          while (codes.size() > cut) void'(codes.pop_back());
          if ($urandom_range(0, 1))
            codes[$urandom_range(0, codes.size() - 1)] = KNOWN_CODES[$urandom_range(0, 10)];
        end
      end
      foreach (codes[i])
        send_item(kind, codes[i], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      sent += codes.size();
    end
  endtask

  initial begin
    int directed;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings
    send_item(i2c_sdra_pkg::KIND_WRITE, i2c_sdra_pkg::ST_START,      8'h00, 8'h00, 8'h00);
    send_item(i2c_sdra_pkg::KIND_WRITE, i2c_sdra_pkg::ST_SLA_W_ACK,  8'hFF, 8'h00, 8'hFF);
    send_item(i2c_sdra_pkg::KIND_WRITE, i2c_sdra_pkg::ST_DATA_ACK,   8'hFF, 8'h00, 8'h00);
    send_item(i2c_sdra_pkg::KIND_WRITE, i2c_sdra_pkg::ST_DATA_ACK,   8'h00, 8'hFF, 8'h00);
    send_item(i2c_sdra_pkg::KIND_READ,  i2c_sdra_pkg::ST_START,      8'hFF, 8'hFF, 8'hFF);
    send_item(i2c_sdra_pkg::KIND_READ,  i2c_sdra_pkg::ST_SLA_W_ACK,  8'h00, 8'hFF, 8'h00);
    send_item(i2c_sdra_pkg::KIND_READ,  i2c_sdra_pkg::ST_DATA_ACK,   8'h5A, 8'h5A, 8'h5A);
    send_item(i2c_sdra_pkg::KIND_READ,  i2c_sdra_pkg::ST_RESTART,    8'h00, 8'h00, 8'h00);
    send_item(i2c_sdra_pkg::KIND_READ,  i2c_sdra_pkg::ST_SLA_R_ACK,  8'h00, 8'h00, 8'h00);
    send_item(i2c_sdra_pkg::KIND_READ,  i2c_sdra_pkg::ST_RX_ACK,     8'h00, 8'h00, 8'hFF);
    send_item(i2c_sdra_pkg::KIND_READ,  i2c_sdra_pkg::ST_RX_ACK,     8'hFF, 8'hFF, 8'h00);
    send_item(i2c_sdra_pkg::KIND_READ,  i2c_sdra_pkg::ST_RX_NACK,    8'h00, 8'h00, 8'hA5);
    send_item(i2c_sdra_pkg::KIND_WRITE, i2c_sdra_pkg::ST_SLA_W_NACK, 8'h00, 8'h00, 8'h00);
    send_item(i2c_sdra_pkg::KIND_READ,  i2c_sdra_pkg::ST_DATA_NACK,  8'h00, 8'h00, 8'h00);
    send_item(i2c_sdra_pkg::KIND_READ,  i2c_sdra_pkg::ST_SLA_R_NACK, 8'h00, 8'h00, 8'h00);
    send_item(i2c_sdra_pkg::KIND_WRITE, i2c_sdra_pkg::ST_DATA_NACK,  8'h00, 8'h00, 8'h00);
    send_item(i2c_sdra_pkg::KIND_READ,  i2c_sdra_pkg::ST_SLA_W_NACK, 8'h00, 8'h00, 8'h00);
    send_item(i2c_sdra_pkg::KIND_WRITE, i2c_sdra_pkg::ST_IDLE,       8'hFF, 8'hFF, 8'hFF);
    send_item(i2c_sdra_pkg::KIND_READ,  i2c_sdra_pkg::ST_IDLE,       8'h00, 8'h00, 8'h00);
    send_item(i2c_sdra_pkg::KIND_WRITE, 8'h00,                       8'h00, 8'h00, 8'h00);
    send_item(i2c_sdra_pkg::KIND_READ,  8'hFF,                       8'hFF, 8'hFF, 8'hFF);
    send_item(i2c_sdra_pkg::KIND_WRITE, i2c_sdra_pkg::ST_RX_ACK,     8'h00, 8'h00, 8'h77);
    send_item(i2c_sdra_pkg::KIND_WRITE, i2c_sdra_pkg::ST_RESTART,    8'h00, 8'h00, 8'h00);
    send_item(i2c_sdra_pkg::KIND_READ,  8'h38,                       8'h00, 8'h00, 8'h00);
    directed = items_sent;
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      set_config(RD_LEN_TAB[p], WR_LEN_TAB[p], ADDR_TAB[p]);
      run_traffic(PHASE_ITEMS);
      drain();
    end

    $display("covered %0d status items (%0d directed) over %0d register settings",
             items_sent, directed, PHASES + 1);
    $display("checked %0d results, %0d received bytes delivered, %0d mismatches",
             results_seen, bytes_stored, fail_count);
    if (fail_count == 0) begin
      $display("i2c_status_driven_register_access regression: pass");
    end else begin
      $display("i2c_status_driven_register_access regression: fail");
    end
    $finish;
  end

endmodule
